// File: design/ntc_pkg.sv
// ============================================================================
// ntc_pkg
// Types, codes and per-stage conversion functions for the numeric type
// converter pipeline.
// ============================================================================
package ntc_pkg;

  // Type codes
  localparam logic [3:0] TY_F32   = 4'd8;
  localparam logic [3:0] TY_C64   = 4'd10;
  localparam logic [3:0] TY_LIMIT = 4'd12;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_TARGET = 1'b1;

  typedef enum logic [1:0] {K_ZERO, K_FIN, K_INF, K_NAN} kind_t;

  // Decoded value: mant * 2^exp, NaN payload left-justified in 52 bits
  typedef struct packed {
    kind_t              kind;
    logic               neg;
    logic               isint;
    logic [63:0]        mant;
    logic signed [12:0] exp;
    logic [51:0]        pl;
  } num_t;

  // Normalized value plus integer-target magnitude
  typedef struct packed {
    kind_t              kind;
    logic               neg;
    logic               isint;
    logic [63:0]        mant;
    logic [63:0]        m;
    logic signed [12:0] be;
    logic [51:0]        pl;
    logic [63:0]        mag;
    logic               ovf;
  } nrm_t;

  // Float lane after the rounding shift
  typedef struct packed {
    kind_t              kind;
    logic               neg;
    logic [51:0]        pl;
    logic signed [12:0] be;
    logic [53:0]        kept;
    logic               rnd;
    logic               sticky;
    logic               ovfl;
    logic               zero_out;
  } rnd_t;

  typedef struct packed {
    logic       unsup;
    logic [3:0] tcode;
    logic       quiet;
    num_t       re;
    num_t       im;
  } s1_t;

  typedef struct packed {
    logic       unsup;
    logic [3:0] tcode;
    logic       quiet;
    nrm_t       re;
    nrm_t       im;
  } s2_t;

  typedef struct packed {
    logic        unsup;
    logic [3:0]  tcode;
    logic        quiet;
    logic [63:0] int_res;
    logic        int_sat;
    rnd_t        re;
    rnd_t        im;
  } s3_t;

  function automatic logic [63:0] width_mask(logic [1:0] wc);
    logic [63:0] r;
    unique case (wc)
      2'd0:    r = 64'h0000_0000_0000_00FF;
      2'd1:    r = 64'h0000_0000_0000_FFFF;
      2'd2:    r = 64'h0000_0000_FFFF_FFFF;
      default: r = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return r;
  endfunction

  function automatic logic is_single(logic [3:0] code);
    return (code == TY_F32) || (code == TY_C64);
  endfunction

  function automatic logic [5:0] frac_bits(logic [3:0] code);
    return is_single(code) ? 6'd23 : 6'd52;
  endfunction

  // Unpack raw bits of the source type
  function automatic num_t ntc_decode(logic [3:0] code, logic [63:0] bits);
    num_t        v;
    logic [63:0] b;
    logic        sb;
    logic [10:0] e;
    logic [51:0] f;
    logic        sgl;
    v = '0;
    v.kind = K_ZERO;
    if (code < TY_F32) begin
      b = bits & width_mask(code[1:0]);
      unique case (code[1:0])
        2'd0:    sb = b[7];
        2'd1:    sb = b[15];
        2'd2:    sb = b[31];
        default: sb = b[63];
      endcase
      v.isint = 1'b1;
      if (!code[2] && sb) begin
        v.neg = 1'b1;
        b = (64'd0 - b) & width_mask(code[1:0]);
      end
      v.mant = b;
      v.kind = (b != 64'd0) ? K_FIN : K_ZERO;
    end else begin
      sgl = is_single(code);
      if (sgl) begin
        e = {3'b000, bits[30:23]};
        f = {29'd0, bits[22:0]};
        v.neg = bits[31];
      end else begin
        e = bits[62:52];
        f = bits[51:0];
        v.neg = bits[63];
      end
      if (e == (sgl ? 11'd255 : 11'd2047)) begin
        if (f == 52'd0) begin
          v.kind = K_INF;
        end else begin
          v.kind = K_NAN;
          v.pl = sgl ? {f[22:0], 29'd0} : f;
        end
      end else if (e == 11'd0) begin
        if (f != 52'd0) begin
          v.kind = K_FIN;
          v.mant = {12'd0, f};
          v.exp = sgl ? -13'sd149 : -13'sd1074;
        end
      end else begin
        v.kind = K_FIN;
        v.mant = {12'd0, f} | (sgl ? (64'd1 << 23) : (64'd1 << 52));
        v.exp = $signed({2'b00, e}) - (sgl ? 13'sd150 : 13'sd1075);
      end
    end
    return v;
  endfunction

  // Normalize and form the integer-target magnitude
  function automatic nrm_t ntc_norm(num_t v);
    nrm_t               n;
    logic [6:0]         lz;
    logic signed [12:0] ne;
    n = '0;
    lz = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (v.mant[i]) lz = 7'(63 - i);
    end
    n.kind  = v.kind;
    n.neg   = v.neg;
    n.isint = v.isint;
    n.mant  = v.mant;
    n.pl    = v.pl;
    n.m     = v.mant << lz[5:0];
    n.be    = v.exp + 13'sd63 - $signed({6'd0, lz});
    ne      = 13'sd0 - v.exp;
    if (v.exp >= 13'sd0) begin
      if (v.exp >= 13'sd64) begin
        n.ovf = 1'b1;
      end else if (v.exp == 13'sd0) begin
        n.mag = v.mant;
      end else begin
        n.ovf = (v.mant >> (7'd64 - v.exp[6:0])) != 64'd0;
        n.mag = v.mant << v.exp[5:0];
      end
    end else if (v.exp > -13'sd64) begin
      n.mag = v.mant >> ne[5:0];
    end
    return n;
  endfunction

  // Align to the target fraction and pick round and sticky bits
  function automatic rnd_t ntc_round(nrm_t n, logic [3:0] tcode);
    rnd_t               r;
    logic               sgl;
    logic signed [12:0] be;
    logic signed [12:0] sh;
    logic [6:0]         sh7;
    logic [5:0]         sm1;
    logic [63:0]        kf;
    sgl = is_single(tcode);
    r = '0;
    r.kind = n.kind;
    r.neg  = n.neg;
    r.pl   = n.pl;
    be = n.be + (sgl ? 13'sd127 : 13'sd1023);
    r.be = be;
    r.ovfl = be >= (sgl ? 13'sd255 : 13'sd2047);
    sh = 13'sd63 - $signed({7'd0, frac_bits(tcode)}) + ((be < 13'sd1) ? (13'sd1 - be) : 13'sd0);
    r.zero_out = sh >= 13'sd65;
    sh7 = sh[6:0];
    sm1 = 6'(sh7 - 7'd1);
    kf = (sh7 == 7'd64) ? 64'd0 : (n.m >> sh7[5:0]);
    r.kept   = kf[53:0];
    r.rnd    = n.m[sm1];
    r.sticky = (n.m & ((64'd1 << sm1) - 64'd1)) != 64'd0;
    return r;
  endfunction

  // Integer target: wrap integers, truncate and saturate floats
  function automatic logic [64:0] ntc_int_enc(nrm_t n, logic [3:0] tcode);
    logic [63:0] mask;
    logic [63:0] lim;
    logic [63:0] res;
    logic        st;
    logic        ovf;
    mask = width_mask(tcode[1:0]);
    lim  = (mask >> 1) + 64'd1;
    res  = 64'd0;
    st   = 1'b0;
    ovf  = n.ovf || (n.kind == K_INF);
    if (n.kind == K_ZERO) begin
      res = 64'd0;
    end else if (n.kind == K_NAN) begin
      st = 1'b1;
    end else if (n.isint) begin
      res = (n.neg ? (64'd0 - n.mant) : n.mant) & mask;
    end else if (!tcode[2]) begin
      if (n.neg) begin
        if (ovf || n.mag > lim) begin
          st = 1'b1;
          res = lim;
        end else begin
          res = (64'd0 - n.mag) & mask;
        end
      end else if (ovf || n.mag > lim - 64'd1) begin
        st = 1'b1;
        res = lim - 64'd1;
      end else begin
        res = n.mag;
      end
    end else if (n.neg) begin
      st = ovf || (n.mag != 64'd0);
    end else if (ovf || n.mag > mask) begin
      st = 1'b1;
      res = mask;
    end else begin
      res = n.mag;
    end
    return {st, res};
  endfunction

  // Round, handle carry-out and pack the float result
  function automatic logic [63:0] ntc_pack(rnd_t r, logic [3:0] tcode, logic quiet);
    logic               sgl;
    logic [53:0]        k2;
    logic signed [12:0] be2;
    logic [51:0]        frac;
    logic [10:0]        ex;
    logic               inf;
    logic               zero;
    sgl  = is_single(tcode);
    k2   = r.kept + {53'd0, r.rnd && (r.sticky || r.kept[0])};
    be2  = r.be;
    frac = 52'd0;
    ex   = 11'd0;
    inf  = 1'b0;
    zero = 1'b0;
    unique case (r.kind)
      K_ZERO: zero = 1'b1;
      K_INF:  inf = 1'b1;
      K_NAN: begin
        ex = 11'h7FF;
        frac = sgl ? {29'd0, r.pl[51:29]} : r.pl;
        if (quiet || frac == 52'd0) begin
          frac = frac | (sgl ? (52'd1 << 22) : (52'd1 << 51));
        end
      end
      default: begin
        if (r.ovfl) begin
          inf = 1'b1;
        end else if (r.zero_out) begin
          zero = 1'b1;
        end else if (r.be < 13'sd1) begin
          // subnormal: a carry into the hidden bit lands on the minimum normal
          ex = sgl ? {10'd0, k2[23]} : {10'd0, k2[52]};
          frac = sgl ? {29'd0, k2[22:0]} : k2[51:0];
        end else begin
          if (sgl ? k2[24] : k2[53]) begin
            k2 = k2 >> 1;
            be2 = be2 + 13'sd1;
          end
          if (be2 >= (sgl ? 13'sd255 : 13'sd2047)) begin
            inf = 1'b1;
          end else begin
            ex = be2[10:0];
            frac = sgl ? {29'd0, k2[22:0]} : k2[51:0];
          end
        end
      end
    endcase
    if (inf) begin
      ex = 11'h7FF;
      frac = 52'd0;
    end else if (zero) begin
      ex = 11'd0;
      frac = 52'd0;
    end
    if (sgl) return {32'd0, r.neg, ex[7:0], frac[22:0]};
    return {r.neg, ex, frac};
  endfunction

endpackage

// File: design/ntc_in_if.sv
// ============================================================================
// ntc_in_if
// Input element channel: valid/ready with raw real and imaginary bits.
// ============================================================================
interface ntc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] real_bits;
  logic [63:0] imag_bits;

  modport source (output valid, output real_bits, output imag_bits, input ready);
  modport sink   (input valid, input real_bits, input imag_bits, output ready);
endinterface

// File: design/ntc_out_if.sv
// ============================================================================
// ntc_out_if
// Result channel: valid/ready with converted bits and status.
// ============================================================================
interface ntc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_real;
  logic [63:0] result_imag;
  logic [1:0]  status;

  modport source (output valid, output result_real, output result_imag, output status,
                  input ready);
  modport sink   (input valid, input result_real, input result_imag, input status,
                  output ready);
endinterface

// File: design/numeric_type_converter.sv
// ============================================================================
// numeric_type_converter
// Element-wise conversion between integer, float and complex numeric types.
// ============================================================================
// Usage:
//   Write source_type (index 0) and target_type (index 1) through the cfg_
//   port while the block is idle, then stream elements on in_ch. Each beat
//   carries real_bits and imag_bits; each result beat on out_ch carries
//   result_real, result_imag and status.
//   Pipeline: decode, normalize, align/round-select, pack. Four register
//   stages: s1_r, s2_r, s3_r and the result registers that drive out_ch.
//   Throughput is one element per cycle while out_ch is ready; the two float
//   lanes and the integer path run side by side in every stage.
//   When out_ch stalls, stages fill up from the output back; in_ch.ready
//   drops only once every stage holds a beat. No beat is dropped or repeated.
//   Synchronous reset clears all stage valid bits and sets both type
//   registers to 0.
module numeric_type_converter (
  input  logic      clk,
  input  logic      rst_n,
  ntc_in_if.sink    in_ch,
  ntc_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [3:0] cfg_wdata
);
  import ntc_pkg::*;

  logic [3:0] src_r, tgt_r;
  logic       v1_r, v2_r, v3_r, v4_r;
  logic       en1, en2, en3, en4;
  s1_t        s1_r, s1_nxt;
  s2_t        s2_r, s2_nxt;
  s3_t        s3_r, s3_nxt;
  logic [63:0] res_re_r, res_re_nxt;
  logic [63:0] res_im_r, res_im_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [64:0] int_enc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= 4'd0;
      tgt_r <= 4'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SOURCE) src_r <= cfg_wdata;
      if (cfg_index == CFG_TARGET) tgt_r <= cfg_wdata;
    end
  end

  // Stage advance: a stage moves when empty or when its successor moves
  assign en4 = !v4_r || out_ch.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  // Stage 1: decode
  always_comb begin
    s1_nxt.unsup = (src_r >= TY_LIMIT) || (tgt_r >= TY_LIMIT);
    s1_nxt.tcode = tgt_r;
    s1_nxt.quiet = (src_r < TY_F32) || (is_single(src_r) != is_single(tgt_r));
    s1_nxt.re    = ntc_decode(src_r, in_ch.real_bits);
    s1_nxt.im    = ntc_decode(src_r, in_ch.imag_bits);
    if (src_r < TY_C64) begin
      s1_nxt.im = '0;
      s1_nxt.im.kind = K_ZERO;
    end
  end

  // Stage 2: normalize
  always_comb begin
    s2_nxt.unsup = s1_r.unsup;
    s2_nxt.tcode = s1_r.tcode;
    s2_nxt.quiet = s1_r.quiet;
    s2_nxt.re    = ntc_norm(s1_r.re);
    s2_nxt.im    = ntc_norm(s1_r.im);
  end

  // Stage 3: align for rounding, finish integer targets
  always_comb begin
    int_enc = ntc_int_enc(s2_r.re, s2_r.tcode);
    s3_nxt.unsup   = s2_r.unsup;
    s3_nxt.tcode   = s2_r.tcode;
    s3_nxt.quiet   = s2_r.quiet;
    s3_nxt.int_res = int_enc[63:0];
    s3_nxt.int_sat = int_enc[64];
    s3_nxt.re      = ntc_round(s2_r.re, s2_r.tcode);
    s3_nxt.im      = ntc_round(s2_r.im, s2_r.tcode);
  end

  // Stage 4: round, pack and select the result
  always_comb begin
    res_re_nxt = 64'd0;
    res_im_nxt = 64'd0;
    st_nxt     = ST_OK;
    if (s3_r.unsup) begin
      st_nxt = ST_UNSUP;
    end else if (s3_r.tcode < TY_F32) begin
      res_re_nxt = s3_r.int_res;
      st_nxt = s3_r.int_sat ? ST_SAT : ST_OK;
    end else begin
      res_re_nxt = ntc_pack(s3_r.re, s3_r.tcode, s3_r.quiet);
      if (s3_r.tcode >= TY_C64) res_im_nxt = ntc_pack(s3_r.im, s3_r.tcode, s3_r.quiet);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s3_nxt;
    if (en4) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      st_r     <= st_nxt;
    end
  end

  assign out_ch.valid       = v4_r;
  assign out_ch.result_real = res_re_r;
  assign out_ch.result_imag = res_im_r;
  assign out_ch.status      = st_r;

  // Checks
  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && st_r == ST_UNSUP) |-> (res_re_r == 64'd0 && res_im_r == 64'd0))
    else $error("unsupported code gave nonzero result");

  a_imag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && tgt_r < TY_C64 && $stable(tgt_r)) |-> (res_im_r == 64'd0))
    else $error("real target gave nonzero imaginary part");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted beat not captured");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (st_r == ST_OK || st_r == ST_SAT || st_r == ST_UNSUP))
    else $error("bad status code");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: numeric_type_converter testbench
// Streams raw element bits through every source/target type pair, predicts
// each converted element with a bit-level software converter and compares
// every result beat in order, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ntc_pkg::*;

  localparam logic [3:0] TY_U8   = 4'd4;
  localparam logic [3:0] TY_F64  = 4'd9;
  localparam logic [3:0] TY_I64  = 4'd3;
  localparam int         IDLE_LIMIT = 2000;
  localparam int         SETTLE = 8;

  typedef struct {
    kind_t       kind;
    bit          neg;
    bit          isint;
    bit [63:0]   mant;
    int          ex;
    bit [63:0]   pl;
  } val_t;

  typedef struct {
    bit [63:0] re;
    bit [63:0] im;
    bit [1:0]  status;
  } elem_t;

  // Predicts converted elements and holds them until the result beats arrive
  class conversion_ledger;
    bit [3:0] src_code;
    bit [3:0] dst_code;
    elem_t    expected_results[$];
    int       mismatches;

    static function bit [63:0] lane_mask(int w);
      return (w >= 64) ? ~64'd0 : ((64'd1 << w) - 64'd1);
    endfunction

    static function void float_format(bit [3:0] code, output int eb, output int fb);
      if (code == TY_F32 || code == TY_C64) begin
        eb = 8; fb = 23;
      end else begin
        eb = 11; fb = 52;
      end
    endfunction

    static function val_t unpack(bit [3:0] code, bit [63:0] raw);
      val_t v;
      int w, eb, fb, bias;
      bit [63:0] b, e, f;
      v.kind = K_ZERO; v.neg = 0; v.isint = 0; v.mant = 0; v.ex = 0; v.pl = 0;
      if (code < TY_F32) begin
        w = 8 << code[1:0];
        b = raw & lane_mask(w);
        v.isint = 1;
        if (code < TY_U8 && b[w-1]) begin
          v.neg = 1;
          b = (64'd0 - b) & lane_mask(w);
          if (b == 0) b = 64'd1 << (w - 1);
        end
        v.mant = b;
        v.kind = (b != 0) ? K_FIN : K_ZERO;
        return v;
      end
      float_format(code, eb, fb);
      raw = raw & lane_mask(eb + fb + 1);
      bias = (1 << (eb - 1)) - 1;
      e = (raw >> fb) & lane_mask(eb);
      f = raw & lane_mask(fb);
      v.neg = raw[eb + fb];
      if (e == lane_mask(eb)) begin
        if (f == 0) v.kind = K_INF;
        else begin
          v.kind = K_NAN;
          v.pl = f << (64 - fb);
        end
      end else if (e == 0) begin
        if (f != 0) begin
          v.kind = K_FIN; v.mant = f; v.ex = 1 - bias - fb;
        end
      end else begin
        v.kind = K_FIN;
        v.mant = f | (64'd1 << fb);
        v.ex = int'(e) - bias - fb;
      end
      return v;
    endfunction

    static function bit [63:0] pack_float(val_t v, int eb, int fb, bit quiet);
      int bias, emax, lz, be, shift;
      bit [63:0] sign, inf, m, kept, frac;
      bit rnd, sticky;
      bias = (1 << (eb - 1)) - 1;
      emax = (1 << eb) - 1;
      sign = v.neg ? (64'd1 << (eb + fb)) : 64'd0;
      inf = sign | (64'(emax) << fb);
      if (v.kind == K_ZERO) return sign;
      if (v.kind == K_INF) return inf;
      if (v.kind == K_NAN) begin
        frac = v.pl >> (64 - fb);
        if (quiet || frac == 0) frac |= 64'd1 << (fb - 1);
        return inf | frac;
      end
      lz = 0;
      m = v.mant;
      while (!m[63]) begin
        m = m << 1;
        lz++;
      end
      be = v.ex + 63 - lz + bias;
      shift = 63 - fb;
      if (be >= emax) return inf;
      if (be < 1) shift += 1 - be;
      if (shift >= 65) return sign;
      kept = (shift == 64) ? 64'd0 : (m >> shift);
      rnd = m[shift-1];
      sticky = (m & lane_mask(shift - 1)) != 0;
      if (rnd && (sticky || kept[0])) kept++;
      if (be < 1) return sign | kept;
      if ((kept >> (fb + 1)) != 0) begin
        kept = kept >> 1;
        be++;
        if (be >= emax) return inf;
      end
      return sign | (64'(be) << fb) | (kept & lane_mask(fb));
    endfunction

    static function bit [63:0] pack_int(val_t v, int w, bit sgn, output bit sat);
      bit [63:0] mask, mag, lim;
      bit ovf;
      mask = lane_mask(w);
      mag = 0;
      ovf = 0;
      sat = 0;
      if (v.kind == K_ZERO) return 0;
      if (v.kind == K_NAN) begin
        sat = 1;
        return 0;
      end
      if (v.isint) return (v.neg ? (64'd0 - v.mant) : v.mant) & mask;
      if (v.kind == K_INF) ovf = 1;
      else if (v.ex >= 0) begin
        if (v.ex == 0) mag = v.mant;
        else if (v.ex >= 64 || (v.mant >> (64 - v.ex)) != 0) ovf = 1;
        else mag = v.mant << v.ex;
      end else if (v.ex > -64) mag = v.mant >> (-v.ex);
      if (sgn) begin
        lim = 64'd1 << (w - 1);
        if (v.neg) begin
          if (ovf || mag > lim) begin
            sat = 1;
            return lim;
          end
          return (64'd0 - mag) & mask;
        end
        if (ovf || mag > lim - 64'd1) begin
          sat = 1;
          return lim - 64'd1;
        end
        return mag;
      end
      if (v.neg) begin
        sat = ovf || (mag != 0);
        return 0;
      end
      if (ovf || mag > mask) begin
        sat = 1;
        return mask;
      end
      return mag;
    endfunction

    function elem_t convert_element(bit [63:0] re_in, bit [63:0] im_in);
      elem_t r;
      val_t vr, vi;
      int eb, fb, seb, sfb;
      bit sat, quiet;
      r.re = 0; r.im = 0; r.status = ST_OK;
      if (src_code >= TY_LIMIT || dst_code >= TY_LIMIT) begin
        r.status = ST_UNSUP;
        return r;
      end
      vr = unpack(src_code, re_in);
      if (src_code >= TY_C64) vi = unpack(src_code, im_in);
      else begin
        vi.kind = K_ZERO; vi.neg = 0; vi.isint = 0; vi.mant = 0; vi.ex = 0; vi.pl = 0;
      end
      if (dst_code < TY_F32) begin
        r.re = pack_int(vr, 8 << dst_code[1:0], dst_code < TY_U8, sat);
        if (sat) r.status = ST_SAT;
      end else begin
        seb = 0; sfb = 0;
        float_format(dst_code, eb, fb);
        if (src_code >= TY_F32) float_format(src_code, seb, sfb);
        quiet = (sfb != fb);
        r.re = pack_float(vr, eb, fb, quiet);
        if (dst_code >= TY_C64) r.im = pack_float(vi, eb, fb, quiet);
      end
      return r;
    endfunction

    function void note_input(bit [63:0] re_in, bit [63:0] im_in);
      expected_results.push_back(convert_element(re_in, im_in));
    endfunction

    function void match_result(bit [63:0] re, bit [63:0] im, bit [1:0] status);
      elem_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: re=%h im=%h status=%0d", re, im, status);
        return;
      end
      e = expected_results.pop_front();
      if (e.re !== re || e.im !== im || e.status !== status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("src=%0d dst=%0d exp re=%h im=%h st=%0d got re=%h im=%h st=%0d",
                   src_code, dst_code, e.re, e.im, e.status, re, im, status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_SOURCE;
  logic [3:0] cfg_wdata = 4'd0;
  bit gaps_on = 1'b1;
  int idle_cycles = 0;
  int stall_left = 0;
  conversion_ledger ledger = new();

  ntc_in_if  in_ch();
  ntc_out_if out_ch();

  numeric_type_converter uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.real_bits = 64'd0;
    in_ch.imag_bits = 64'd0;
    out_ch.ready = 1'b0;
  end

  // Stall the result channel in short random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check every result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      ledger.match_result(out_ch.result_real, out_ch.result_imag, out_ch.status);
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("numeric_type_converter: mismatch");
      $finish;
    end
  end

  // Write both type registers, keeping the predictor in step
  task automatic set_types(bit [3:0] src, bit [3:0] dst);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SOURCE;
    cfg_wdata <= src;
    @(negedge clk);
    cfg_index <= CFG_TARGET;
    cfg_wdata <= dst;
    @(negedge clk);
    cfg_we <= 1'b0;
    ledger.src_code = src;
    ledger.dst_code = dst;
  endtask

  // Send one element beat, with an optional gap ahead of it
  task automatic push_elem(bit [63:0] re, bit [63:0] im);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.real_bits <= re;
    in_ch.imag_bits <= im;
    do @(posedge clk); while (!in_ch.ready);
    ledger.note_input(re, im);
    @(negedge clk);
  endtask

  // Drop valid, hold until every result is back, then let the pipe settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (ledger.expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic bit [63:0] make_fp(bit neg, bit [63:0] e, bit [63:0] f, int eb, int fb);
    return (64'(neg) << (eb + fb)) | ((e & conversion_ledger::lane_mask(eb)) << fb)
           | (f & conversion_ledger::lane_mask(fb));
  endfunction

  // Raw operand biased toward the interesting corners of the source type
  function automatic bit [63:0] pick_operand(bit [3:0] code);
    bit [63:0] r, f, e;
    int eb, fb, bias;
    r = {$urandom, $urandom};
    if (code < TY_F32 || code >= TY_LIMIT) begin
      case ($urandom_range(0, 3))
        0: return r;
        1: begin
          case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return ~64'd0;
            2: return 64'd1 << (8 * $urandom_range(1, 8) - 1);
            3: return ~(64'd1 << (8 * $urandom_range(1, 8) - 1));
            4: return 64'd1;
            default: return conversion_ledger::lane_mask(8 * $urandom_range(1, 8));
          endcase
        end
        2: return r & 64'hFF;
        default: return r | ~64'hFF;
      endcase
    end
    conversion_ledger::float_format(code, eb, fb);
    bias = (1 << (eb - 1)) - 1;
    f = r;
    if ($urandom_range(0, 2) == 0) f = f & ~conversion_ledger::lane_mask($urandom_range(0, fb));
    case ($urandom_range(0, 7))
      0: return r;
      1: e = conversion_ledger::lane_mask(eb) ; // all-ones exponent: infinity if f is zero, else NaN
      2: begin
        e = conversion_ledger::lane_mask(eb);
        f = f & conversion_ledger::lane_mask(fb);
        if (f == 0) f = 64'd1 << $urandom_range(0, fb - 1);
      end
      3: e = 0;
      4, 5: e = bias + $urandom_range(0, 66) - $urandom_range(0, 3);
      6: e = (eb == 11) ? (1023 - 126 - $urandom_range(0, 26) + $urandom_range(0, 2))
                        : bias + $urandom_range(0, 66);
      default: begin
        e = (eb == 11) ? (1023 + 126 + $urandom_range(0, 2))
                       : conversion_ledger::lane_mask(eb) - 1;
        if ($urandom_range(0, 1) == 0) f = ~64'd0;
      end
    endcase
    if (e == conversion_ledger::lane_mask(eb) && f != 0 && $urandom_range(0, 7) == 0) f = 0;
    return make_fp($urandom_range(0, 1), e, f, eb, fb) |
           (($urandom_range(0, 3) == 0) ? (r & ~conversion_ledger::lane_mask(eb + fb + 1)) : 0);
  endfunction

  bit [63:0] corner_f64[12] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3FF8_0000_0000_0000,
    64'hC004_0000_0000_0000, 64'h43E0_0000_0000_0000, 64'hC3E0_0000_0000_0000,
    64'h43F0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
    64'h7FF0_0000_0000_0001, 64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF
  };

  initial begin
    int n_items, phase;
    bit [3:0] src;
    bit [3:0] dst;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners: double into int64, then into single
    set_types(TY_F64, TY_I64);
    foreach (corner_f64[i]) push_elem(corner_f64[i], 64'd0);
    drain();
    set_types(TY_F64, TY_F32);
    foreach (corner_f64[i]) push_elem(corner_f64[i], ~corner_f64[i]);
    drain();

    // Every register pair, unsupported codes included; drain between pairs
    phase = 0;
    for (int s = 0; s < 16; s++) begin
      for (int t = 0; t < 16; t++) begin
        src = 4'(s);
        dst = 4'(t);
        if (phase >= 230) gaps_on = 1'b0;
        set_types(src, dst);
        n_items = $urandom_range(4, 9);
        repeat (n_items) push_elem(pick_operand(src), pick_operand(src));
        drain();
        phase++;
      end
    end

    if (ledger.mismatches == 0 && ledger.expected_results.size() == 0)
      $display("numeric_type_converter: match");
    else
      $display("numeric_type_converter: mismatch");
    $finish;
  end
endmodule
